// File: rtl/sqct_pkg.sv
// ---------------------------------------------------------------------------
// sqct_pkg
// Shared types, widths, register indexes and the sine table generator for
// the sprite quad corner transform.
// ---------------------------------------------------------------------------
`default_nettype none

package sqct_pkg;

   localparam int SineTableBitsDefault = 10;
   localparam int CoordW   = 24;
   localparam int SizeW    = 23;
   localparam int ScaleW   = 16;
   localparam int AngleW   = 16;
   localparam int ExtW     = 25;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 24;

   // one-in-Q8.8 scale used for translate beats
   localparam logic signed [ScaleW-1:0] ScaleOne = 16'sd256;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPRITE_WIDTH  = 2'd0,
      CSR_SPRITE_HEIGHT = 2'd1,
      CSR_HOTSPOT_X     = 2'd2,
      CSR_HOTSPOT_Y     = 2'd3
   } csr_index_type;

   // one classified beat between front and back
   typedef struct packed {
      logic signed [ExtW-1:0]   left;
      logic signed [ExtW-1:0]   right;
      logic signed [ExtW-1:0]   top;
      logic signed [ExtW-1:0]   bottom;
      logic signed [ScaleW-1:0] scale_x;
      logic signed [ScaleW-1:0] scale_top;
      logic signed [ScaleW-1:0] scale_bottom;
      logic [AngleW-1:0]        angle;
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
   } work_type;

   // quarter-wave sine entry, Q14, Taylor series to degree 13 in Q30
   function automatic logic [14:0] qsine_entry(int unsigned idx, int unsigned qbits);
      logic [63:0] x;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] r;
      x = (64'd1686629713 * 64'(idx)) >> qbits;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 6; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         unique case (k)
            1: term = term / 64'd6;
            2: term = term / 64'd20;
            3: term = term / 64'd42;
            4: term = term / 64'd72;
            5: term = term / 64'd110;
            default: term = term / 64'd156;
         endcase
         if ((k % 2) == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      r = ($unsigned(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      return r[14:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/sqct_front.sv
// ---------------------------------------------------------------------------
// sqct_front
// Holds the sprite registers, accepts placements and classifies them into
// extents, per-edge scales and an effective angle.
// ---------------------------------------------------------------------------
`default_nettype none

module sqct_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [sqct_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [sqct_pkg::CsrDataW-1:0] csr_data,
   input  wire logic                          take,
   input  wire logic                          opcode,
   input  wire logic [sqct_pkg::CoordW-1:0]   pos_x,
   input  wire logic [sqct_pkg::CoordW-1:0]   pos_y,
   input  wire logic [sqct_pkg::AngleW-1:0]   angle,
   input  wire logic [sqct_pkg::ScaleW-1:0]   scale_x,
   input  wire logic [sqct_pkg::ScaleW-1:0]   scale_y,
   output logic                               push,
   output sqct_pkg::work_type                 push_data
);
   import sqct_pkg::*;

   logic [SizeW-1:0]  width_ff, height_ff;
   logic [CoordW-1:0] hot_x_ff, hot_y_ff;
   logic              valid_ff;
   work_type          work_ff, work_in;
   logic signed [ScaleW-1:0] sx, sy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         hot_x_ff  <= '0;
         hot_y_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRITE_WIDTH:  width_ff  <= csr_data[SizeW-1:0];
            CSR_SPRITE_HEIGHT: height_ff <= csr_data[SizeW-1:0];
            CSR_HOTSPOT_X:     hot_x_ff  <= csr_data;
            CSR_HOTSPOT_Y:     hot_y_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // classify: translate is rotate-scale with unit scale and zero angle
   always_comb begin
      sx = $signed(scale_x);
      sy = $signed(scale_y);
      work_in.left   = ExtW'(0) - $signed({hot_x_ff[CoordW-1], hot_x_ff});
      work_in.top    = ExtW'(0) - $signed({hot_y_ff[CoordW-1], hot_y_ff});
      work_in.right  = $signed({2'b00, width_ff}) - $signed({hot_x_ff[CoordW-1], hot_x_ff});
      work_in.bottom = $signed({2'b00, height_ff}) - $signed({hot_y_ff[CoordW-1], hot_y_ff});
      work_in.pos_x  = $signed(pos_x);
      work_in.pos_y  = $signed(pos_y);
      if (opcode) begin
         work_in.scale_x      = sx;
         work_in.scale_top    = sy;
         work_in.scale_bottom = (sy == '0) ? sx : sy;
         work_in.angle        = angle;
      end else begin
         work_in.scale_x      = ScaleOne;
         work_in.scale_top    = ScaleOne;
         work_in.scale_bottom = ScaleOne;
         work_in.angle        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= take;
      if (take) work_ff <= work_in;
   end

   assign push      = valid_ff;
   assign push_data = work_ff;

endmodule

`default_nettype wire

// File: rtl/sqct_queue.sv
// ---------------------------------------------------------------------------
// sqct_queue
// Two-entry queue of classified beats between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module sqct_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  sqct_pkg::work_type      push_data,
   output logic                    pop,
   output sqct_pkg::work_type      pop_data,
   output logic                    full
);
   import sqct_pkg::*;

   work_type    slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   // back end never stalls, so any held beat leaves at once
   assign pop      = (count_ff != 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// File: rtl/sqct_back.sv
// ---------------------------------------------------------------------------
// sqct_back
// Three-stage datapath: edge scaling with sine lookup, rotation products,
// then rounding and the position offset.
// ---------------------------------------------------------------------------
`default_nettype none

module sqct_back #(
   parameter int SINE_TABLE_BITS = sqct_pkg::SineTableBitsDefault
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop,
   input  sqct_pkg::work_type               pop_data,
   output logic                             rsp_valid,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner0_x,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner0_y,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner1_x,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner1_y,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner2_x,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner2_y,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner3_x,
   output logic [sqct_pkg::CoordW-1:0]      rsp_corner3_y
);
   import sqct_pkg::*;

   localparam int QBits  = SINE_TABLE_BITS - 2;
   localparam int Qtr    = 1 << QBits;
   localparam int Shift  = AngleW - SINE_TABLE_BITS;
   localparam int ProdW  = ExtW + ScaleW;   // extent times scale
   localparam int EdgeW  = ProdW - 8;       // rounded edge
   localparam int RotW   = EdgeW + 16;      // edge times sine
   localparam int SumW   = RotW + 1;

   // quarter-wave table
   logic [14:0] qsine [Qtr+1];
   for (genvar g = 0; g <= Qtr; g++) begin : g_tbl
      assign qsine[g] = qsine_entry(g, QBits);
   end

   // ---------------- stage 1: edge products, sine and cosine
   logic [AngleW:0]          ang_round;
   logic [SINE_TABLE_BITS-1:0] n_sin, n_cos;
   logic [QBits:0]           sin_idx, cos_idx;
   logic signed [15:0]       sin_val, cos_val;
   logic                     v1_ff;
   logic signed [ProdW-1:0]  pl_ff, pr_ff, pt_ff, pb_ff;
   logic signed [15:0]       sin_ff, cos_ff;
   logic signed [CoordW-1:0] px1_ff, py1_ff, px2_ff, py2_ff;

   always_comb begin
      ang_round = ({1'b0, pop_data.angle} + (AngleW+1)'(1 << (Shift - 1))) >> Shift;
      n_sin = ang_round[SINE_TABLE_BITS-1:0];
      n_cos = n_sin + SINE_TABLE_BITS'(Qtr);
      sin_idx = n_sin[SINE_TABLE_BITS-2] ? (QBits+1)'(Qtr) - {1'b0, n_sin[QBits-1:0]}
                                         : {1'b0, n_sin[QBits-1:0]};
      cos_idx = n_cos[SINE_TABLE_BITS-2] ? (QBits+1)'(Qtr) - {1'b0, n_cos[QBits-1:0]}
                                         : {1'b0, n_cos[QBits-1:0]};
      sin_val = n_sin[SINE_TABLE_BITS-1] ? -$signed({1'b0, qsine[sin_idx]})
                                         : $signed({1'b0, qsine[sin_idx]});
      cos_val = n_cos[SINE_TABLE_BITS-1] ? -$signed({1'b0, qsine[cos_idx]})
                                         : $signed({1'b0, qsine[cos_idx]});
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= pop;
      if (pop) begin
         pl_ff  <= ProdW'(pop_data.left * pop_data.scale_x);
         pr_ff  <= ProdW'(pop_data.right * pop_data.scale_x);
         pt_ff  <= ProdW'(pop_data.top * pop_data.scale_top);
         pb_ff  <= ProdW'(pop_data.bottom * pop_data.scale_bottom);
         sin_ff <= sin_val;
         cos_ff <= cos_val;
         px1_ff <= pop_data.pos_x;
         py1_ff <= pop_data.pos_y;
      end
   end

   // ---------------- stage 2: round edges, rotation products
   logic signed [EdgeW-1:0] el, er, et, eb;
   logic                    v2_ff;
   logic signed [RotW-1:0]  lc_ff, ls_ff, rc_ff, rs_ff, tc_ff, ts_ff, bc_ff, bs_ff;

   always_comb begin
      el = EdgeW'((pl_ff + ProdW'(128)) >>> 8);
      er = EdgeW'((pr_ff + ProdW'(128)) >>> 8);
      et = EdgeW'((pt_ff + ProdW'(128)) >>> 8);
      eb = EdgeW'((pb_ff + ProdW'(128)) >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      if (v1_ff) begin
         lc_ff <= RotW'(el * cos_ff);
         ls_ff <= RotW'(el * sin_ff);
         rc_ff <= RotW'(er * cos_ff);
         rs_ff <= RotW'(er * sin_ff);
         tc_ff <= RotW'(et * cos_ff);
         ts_ff <= RotW'(et * sin_ff);
         bc_ff <= RotW'(eb * cos_ff);
         bs_ff <= RotW'(eb * sin_ff);
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
      end
   end

   // ---------------- stage 3: combine, round Q.14 to Q.0, add position
   function automatic logic [CoordW-1:0] finish(logic signed [SumW-1:0] v,
                                                logic signed [CoordW-1:0] p);
      logic signed [SumW-1:0] r;
      r = (v + SumW'(8192)) >>> 14;
      return r[CoordW-1:0] + p;
   endfunction

   logic signed [SumW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
   always_comb begin
      x0 = SumW'(lc_ff) - SumW'(ts_ff);  y0 = SumW'(ls_ff) + SumW'(tc_ff);
      x1 = SumW'(rc_ff) - SumW'(ts_ff);  y1 = SumW'(rs_ff) + SumW'(tc_ff);
      x2 = SumW'(rc_ff) - SumW'(bs_ff);  y2 = SumW'(rs_ff) + SumW'(bc_ff);
      x3 = SumW'(lc_ff) - SumW'(bs_ff);  y3 = SumW'(ls_ff) + SumW'(bc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= v2_ff;
      if (v2_ff) begin
         rsp_corner0_x <= finish(x0, px2_ff);
         rsp_corner0_y <= finish(y0, py2_ff);
         rsp_corner1_x <= finish(x1, px2_ff);
         rsp_corner1_y <= finish(y1, py2_ff);
         rsp_corner2_x <= finish(x2, px2_ff);
         rsp_corner2_y <= finish(y2, py2_ff);
         rsp_corner3_x <= finish(x3, px2_ff);
         rsp_corner3_y <= finish(y3, py2_ff);
      end
   end

endmodule

`default_nettype wire

// File: rtl/sprite_quad_corner_transform_top.sv
// ---------------------------------------------------------------------------
// sprite_quad_corner_transform_top
// Sprite placement to screen quad corners, rotate-scale-translate.
//
//   channel | ports                                   | handshake
//   req     | req_opcode, req_pos_*, req_angle, req_scale_* | start & !busy
//   rsp     | rsp_corner{0..3}_{x,y}                  | rsp_valid, one cycle
//   csr     | csr_index, csr_data                     | csr_we
//
// One placement per cycle while busy is low. The front register loads at the
// accept edge, then the queue slot and the three datapath stages are registered
// in turn; rsp_valid rises with the last of them, together with the result.
// Synchronous reset clears the sprite registers and all valid flags. The result
// side cannot stall; busy rises only if the two-entry queue fills.
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_quad_corner_transform_top #(
   parameter int SINE_TABLE_BITS = sqct_pkg::SineTableBitsDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [sqct_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [sqct_pkg::CsrDataW-1:0] csr_data,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_opcode,
   input  wire logic [sqct_pkg::CoordW-1:0]   req_pos_x,
   input  wire logic [sqct_pkg::CoordW-1:0]   req_pos_y,
   input  wire logic [sqct_pkg::AngleW-1:0]   req_angle,
   input  wire logic [sqct_pkg::ScaleW-1:0]   req_scale_x,
   input  wire logic [sqct_pkg::ScaleW-1:0]   req_scale_y,
   output logic                               rsp_valid,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner0_x,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner0_y,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner1_x,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner1_y,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner2_x,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner2_y,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner3_x,
   output logic [sqct_pkg::CoordW-1:0]        rsp_corner3_y
);
   import sqct_pkg::*;

   logic     take, push, pop, full;
   work_type push_data, pop_data;

   assign take = start & ~busy;
   assign busy = full;

   sqct_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_data, .take,
      .opcode(req_opcode), .pos_x(req_pos_x), .pos_y(req_pos_y), .angle(req_angle),
      .scale_x(req_scale_x), .scale_y(req_scale_y), .push, .push_data
   );

   sqct_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .full
   );

   sqct_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
      .clock, .reset, .pop, .pop_data, .rsp_valid,
      .rsp_corner0_x, .rsp_corner0_y, .rsp_corner1_x, .rsp_corner1_y,
      .rsp_corner2_x, .rsp_corner2_y, .rsp_corner3_x, .rsp_corner3_y
   );

endmodule

`default_nettype wire

// File: rtl/sqct_checker.sv
// ---------------------------------------------------------------------------
// sqct_checker
// Port-level checks on beat latency and flow for the quad transform.
// ---------------------------------------------------------------------------
`default_nettype none

module sqct_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // every accepted beat comes back as a result strobe through the front, queue and datapath registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted beat did not produce a result");

   // no result without a matching accept
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without an accepted beat");

   // result side never stalls, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // reset clears the result strobe
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind sprite_quad_corner_transform_top sqct_checker u_sqct_checker (
   .clock, .reset, .start, .busy, .rsp_valid
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite quad corner transform. A local
// predictor computes the four corners of every accepted placement. Results
// are matched in order, one field at a time. The sprite registers are set
// while the block is idle. Directed placements come first, then random ones
// under several register settings, with random request-side gaps in all but one of them.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import sqct_pkg::*;

   localparam int TableBits = SineTableBitsDefault;
   localparam int QtrSteps  = 1 << (TableBits - 2);
   localparam int DrainCycles = 10;
   localparam int StallLimit  = 2000;

   typedef logic [7:0][CoordW-1:0] corners_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   csr_index_type       csr_index = CSR_SPRITE_WIDTH;
   logic [CsrDataW-1:0] csr_data = '0;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = 1'b0;
   logic [CoordW-1:0]   req_pos_x = '0;
   logic [CoordW-1:0]   req_pos_y = '0;
   logic [AngleW-1:0]   req_angle = '0;
   logic [ScaleW-1:0]   req_scale_x = '0;
   logic [ScaleW-1:0]   req_scale_y = '0;
   logic                rsp_valid;
   corners_type         rsp_corners;

   // sprite registers as the predictor sees them
   longint              spr_width, spr_height, spr_hot_x, spr_hot_y;
   longint              quarter_sine [0:QtrSteps];
   corners_type         pending_quads [$];
   int                  beats_taken = 0;
   int                  idle_cycles = 0;
   bit                  gaps_on = 1'b1;
   bit                  failed = 1'b0;

   sprite_quad_corner_transform_top i_dut (
      .clock, .reset, .csr_we, .csr_index, .csr_data, .start, .busy,
      .req_opcode, .req_pos_x, .req_pos_y, .req_angle, .req_scale_x, .req_scale_y,
      .rsp_valid,
      .rsp_corner0_x(rsp_corners[0]), .rsp_corner0_y(rsp_corners[1]),
      .rsp_corner1_x(rsp_corners[2]), .rsp_corner1_y(rsp_corners[3]),
      .rsp_corner2_x(rsp_corners[4]), .rsp_corner2_y(rsp_corners[5]),
      .rsp_corner3_x(rsp_corners[6]), .rsp_corner3_y(rsp_corners[7])
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // quarter-wave sine in Q14 from a degree-13 series evaluated in Q30
   function automatic void fill_sine_quarter();
      longint unsigned x, term, r;
      longint          sum;
      for (int i = 0; i <= QtrSteps; i++) begin
         x = (64'd1686629713 * longint'(i)) / QtrSteps;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         r = (longint'(sum) + 32768) >> 16;
         if (r > 16384) r = 16384;
         quarter_sine[i] = longint'(r);
      end
   endfunction

   function automatic longint sine_of(int unsigned n);
      int unsigned quad, r;
      n = n % (1 << TableBits);
      quad = n / QtrSteps;
      r = n % QtrSteps;
      case (quad)
         0: return quarter_sine[r];
         1: return quarter_sine[QtrSteps - r];
         2: return -quarter_sine[r];
         default: return -quarter_sine[QtrSteps - r];
      endcase
   endfunction

   // floor((v + half) / 2^s)
   function automatic longint round_down_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic corners_type transform_quad(logic op, logic [CoordW-1:0] px_raw,
                                                  logic [CoordW-1:0] py_raw,
                                                  logic [AngleW-1:0] ang,
                                                  logic [ScaleW-1:0] sx_raw,
                                                  logic [ScaleW-1:0] sy_raw);
      longint      px, py, sx, sy, sy_far, x1, y1, x2, y2, s, c;
      longint      lx [4], ly [4], cx [4], cy [4];
      int unsigned n;
      corners_type q;
      px = longint'($signed(px_raw));
      py = longint'($signed(py_raw));
      sx = longint'($signed(sx_raw));
      sy = longint'($signed(sy_raw));
      if (!op) begin
         x1 = px - spr_hot_x;
         y1 = py - spr_hot_y;
         x2 = px + spr_width - spr_hot_x;
         y2 = py + spr_height - spr_hot_y;
         lx = '{x1, x2, x2, x1};
         ly = '{y1, y1, y2, y2};
         cx = lx;
         cy = ly;
      end else begin
         sy_far = (sy == 0) ? sx : sy;
         x1 = round_down_q(-spr_hot_x * sx, 8);
         y1 = round_down_q(-spr_hot_y * sy, 8);
         x2 = round_down_q((spr_width - spr_hot_x) * sx, 8);
         y2 = round_down_q((spr_height - spr_hot_y) * sy_far, 8);
         lx = '{x1, x2, x2, x1};
         ly = '{y1, y1, y2, y2};
         if (ang == 0) begin
            s = 0;
            c = 16384;
         end else begin
            n = (int'(ang) + (1 << (15 - TableBits))) >> (16 - TableBits);
            s = sine_of(n);
            c = sine_of(n + QtrSteps);
         end
         for (int k = 0; k < 4; k++) begin
            cx[k] = round_down_q(lx[k] * c - ly[k] * s, 14) + px;
            cy[k] = round_down_q(lx[k] * s + ly[k] * c, 14) + py;
         end
      end
      for (int k = 0; k < 4; k++) begin
         q[2 * k]     = cx[k][CoordW-1:0];
         q[2 * k + 1] = cy[k][CoordW-1:0];
      end
      return q;
   endfunction

   // request beat accepted: queue its corners
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         pending_quads.push_back(transform_quad(req_opcode, req_pos_x, req_pos_y, req_angle,
                                                req_scale_x, req_scale_y));
         beats_taken <= beats_taken + 1;
      end
   end

   // result beat: compare against the oldest expectation
   always @(posedge clock) begin
      corners_type want;
      if (!reset && rsp_valid) begin
         if (pending_quads.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, rsp_corners);
            failed = 1'b1;
         end else begin
            want = pending_quads.pop_front();
            for (int f = 0; f < 8; f++) begin
               if (want[f] !== rsp_corners[f]) begin
                  $display("%0t: corner%0d_%s expected %h actual %h", $time, f / 2,
                           (f % 2) ? "y" : "x", want[f], rsp_corners[f]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("sprite_quad_corner_transform_top test failed");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SPRITE_WIDTH:  spr_width  = longint'(val[SizeW-1:0]);
         CSR_SPRITE_HEIGHT: spr_height = longint'(val[SizeW-1:0]);
         CSR_HOTSPOT_X:     spr_hot_x  = longint'($signed(val));
         default:           spr_hot_y  = longint'($signed(val));
      endcase
   endtask

   task automatic wait_drained();
      while (pending_quads.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_sprite(logic [23:0] w, logic [23:0] h, logic [23:0] hx, logic [23:0] hy);
      wait_drained();
      write_reg(CSR_SPRITE_WIDTH, w);
      write_reg(CSR_SPRITE_HEIGHT, h);
      write_reg(CSR_HOTSPOT_X, hx);
      write_reg(CSR_HOTSPOT_Y, hy);
   endtask

   // one placement beat, with an optional gap before it
   task automatic send_placement(logic op, logic [23:0] px, logic [23:0] py,
                                 logic [15:0] ang, logic [15:0] sx, logic [15:0] sy);
      int gap;
      int target;
      gap = gaps_on ? int'($urandom_range(0, 6)) : 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_opcode = op;
      req_pos_x = px;
      req_pos_y = py;
      req_angle = ang;
      req_scale_x = sx;
      req_scale_y = sy;
      target = beats_taken + 1;
      do @(negedge clock); while (beats_taken != target);
   endtask

   task automatic test_translate();
      set_sprite(24'h001000, 24'h000800, 24'h000100, 24'hFFFF80);
      send_placement(1'b0, 24'h000000, 24'h000000, 16'h0000, 16'h0100, 16'h0100);
      send_placement(1'b0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_placement(1'b0, 24'h800000, 24'h800000, 16'h1234, 16'h8000, 16'h0000);
      send_placement(1'b0, 24'hFFFFFF, 24'h000001, 16'h4000, 16'hFFFF, 16'hFFFF);
      start = 1'b0;
      set_sprite(24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_placement(1'b0, 24'h7FFFFF, 24'h800000, 16'h0000, 16'h0100, 16'h0100);
      send_placement(1'b0, 24'h800000, 24'h7FFFFF, 16'h0000, 16'h0100, 16'h0100);
   endtask

   task automatic test_rotate_scale();
      logic [15:0] angles [10] = '{16'h0000, 16'h001F, 16'h0020, 16'h0040, 16'h4000,
                                   16'h8000, 16'hC000, 16'h2000, 16'hFFE0, 16'hFFFF};
      start = 1'b0;
      set_sprite(24'h002000, 24'h001000, 24'h000800, 24'h000400);
      foreach (angles[i])
         send_placement(1'b1, 24'h012345, 24'hFEDCBA, angles[i], 16'h0180, 16'h0080);
      // zero y scale: far edge takes x scale, near edge collapses
      send_placement(1'b1, 24'h001000, 24'h002000, 16'h0000, 16'h0200, 16'h0000);
      send_placement(1'b1, 24'h001000, 24'h002000, 16'h3000, 16'hFF00, 16'h0000);
      send_placement(1'b1, 24'h7FFFFF, 24'h800000, 16'h1000, 16'h7FFF, 16'h8000);
      send_placement(1'b1, 24'h800000, 24'h7FFFFF, 16'hA000, 16'h8000, 16'h7FFF);
      start = 1'b0;
      set_sprite(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
      send_placement(1'b1, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h7FFF, 16'h7FFF);
      send_placement(1'b1, 24'h000000, 24'h000000, 16'h6000, 16'h8000, 16'h0000);
      send_placement(1'b1, 24'h800000, 24'h800000, 16'hE123, 16'h8000, 16'h8000);
   endtask

   task automatic test_random_placements();
      logic [15:0] ang, sy;
      for (int phase = 0; phase < 6; phase++) begin
         start = 1'b0;
         case (phase)
            0: set_sprite(24'h000000, 24'h000000, 24'h000000, 24'h000000);
            1: set_sprite(24'h7FFFFF, 24'h000000, 24'h7FFFFF, 24'h800000);
            default: set_sprite(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         endcase
         gaps_on = (phase != 2);
         for (int i = 0; i < 75; i++) begin
            case ($urandom_range(0, 5))
               0: ang = 16'h0000;
               1: ang = 16'($urandom_range(0, 40));
               default: ang = 16'($urandom);
            endcase
            sy = ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom);
            send_placement(1'($urandom), 24'($urandom), 24'($urandom), ang,
                           16'($urandom), sy);
         end
      end
      start = 1'b0;
   endtask

   initial begin
      fill_sine_quarter();
      spr_width = 0;
      spr_height = 0;
      spr_hot_x = 0;
      spr_hot_y = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_translate();
      test_rotate_scale();
      test_random_placements();
      wait_drained();
      if (!failed) $display("sprite_quad_corner_transform_top test passed");
      else $display("sprite_quad_corner_transform_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
